/* sv/fractional_frame_pacer_macros.svh */
// assertion macros shared by the pacer rtl
`ifndef FRACTIONAL_FRAME_PACER_MACROS_SVH
`define FRACTIONAL_FRAME_PACER_MACROS_SVH

// condition holds at every clock edge out of reset
`define FFP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define FFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define FFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ffp_pkg.sv */
// types and constants of the fractional frame pacer
`default_nettype none

package ffp_pkg;

  localparam int TIME_WIDTH  = 64;
  localparam int COUNT_WIDTH = 32;
  localparam int FRAC_WIDTH  = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int OP_WIDTH    = 2;

  // input tdata carries now_ns only, padded to whole bytes
  localparam int IN_TDATA_W = ((TIME_WIDTH + 7) / 8) * 8;

  // register reset values
  localparam logic                  THROTTLED_RST = 1'b1;
  localparam logic [FRAC_WIDTH-1:0] FLOOR_RST     = FRAC_WIDTH'(16639267);
  localparam logic [FRAC_WIDTH-1:0] REMAINDER_RST = '0;
  localparam logic [FRAC_WIDTH-1:0] DENOM_RST     = FRAC_WIDTH'(1);

  // event codes carried in tuser; code 3 means nothing
  typedef enum logic [OP_WIDTH-1:0] {
    OP_START      = 2'd0,
    OP_FRAME_DONE = 2'd1,
    OP_QUERY      = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THROTTLED = 2'd0,
    CFG_FLOOR     = 2'd1,
    CFG_REMAINDER = 2'd2,
    CFG_DENOM     = 2'd3
  } cfg_index_t;

  // result word, first member in the highest bits so should_wait lands at bit 0
  typedef struct packed {
    logic [TIME_WIDTH-1:0]  max_lateness;
    logic [TIME_WIDTH-1:0]  last_lateness;
    logic [TIME_WIDTH-1:0]  total_frame_time;
    logic [TIME_WIDTH-1:0]  worst_frame_time;
    logic [TIME_WIDTH-1:0]  last_frame_time;
    logic [COUNT_WIDTH-1:0] late_frames;
    logic [COUNT_WIDTH-1:0] frames_done;
    logic [TIME_WIDTH-1:0]  wait_until;
    logic                   should_wait;
  } result_t;

  localparam int OUT_BITS    = $bits(result_t);
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // pacing and statistics state
  typedef struct packed {
    logic [TIME_WIDTH-1:0]  start_time;
    logic [TIME_WIDTH-1:0]  wait_target;
    logic [TIME_WIDTH-1:0]  next_deadline;
    logic [FRAC_WIDTH-1:0]  fraction_acc;
    logic                   have_previous;
    logic [TIME_WIDTH-1:0]  previous_done_time;
    logic [COUNT_WIDTH-1:0] frame_counter;
    logic [COUNT_WIDTH-1:0] late_counter;
    logic [TIME_WIDTH-1:0]  last_duration;
    logic [TIME_WIDTH-1:0]  worst_duration;
    logic [TIME_WIDTH-1:0]  duration_sum;
    logic [TIME_WIDTH-1:0]  last_late;
    logic [TIME_WIDTH-1:0]  max_late;
  } state_t;

endpackage

`default_nettype wire

/* sv/fractional_frame_pacer.sv */
// fractional frame pacer: deadline pacing and frame timing statistics
//
// Each event word (start, frame done or wait query, with a nanosecond
// timestamp) yields exactly one result word holding the wait decision, the
// wait target and the frame statistics after that event. The block takes one
// event word per cycle while the sink takes results. An accepted word is held
// in an input register, is evaluated against the pacing state in a single pass
// of adders and comparators (the 64-bit deadline step and the duration/lateness
// updates), and its result is registered in the output register, from which it
// is offered to the sink. The output register keeps the result while the sink
// stalls; the input side keeps accepting until both registers are full.
// Configuration writes take effect at once and belong to idle periods.
`default_nettype none

module fractional_frame_pacer
  import ffp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // event input
  input  wire logic                   s_tvalid,
  output      logic                   s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // now_ns
  input  wire logic [OP_WIDTH-1:0]    s_tuser,   // op
  // result output
  output      logic                   m_tvalid,
  input  wire logic                   m_tready,
  // should_wait, wait_until, frames_done, late_frames, last_frame_time,
  // worst_frame_time, total_frame_time, last_lateness, max_lateness, zero pad
  output      logic [OUT_TDATA_W-1:0] m_tdata,
  // configuration writes
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

`include "fractional_frame_pacer_macros.svh"

  // configuration registers
  logic                  throttled;
  logic [FRAC_WIDTH-1:0] frame_floor_ns;
  logic [FRAC_WIDTH-1:0] frame_remainder;
  logic [FRAC_WIDTH-1:0] frame_denominator;

  // input register
  logic                  in_valid;
  logic [OP_WIDTH-1:0]   in_op;
  logic [TIME_WIDTH-1:0] in_now;

  // output register
  logic                  out_valid;
  result_t               out_res;
  result_t               res_next;

  // pacing state
  state_t                st;
  state_t                st_next;

  // handshake
  logic                  in_fire;
  logic                  eval_fire;
  logic                  out_fire;

  // shared deadline step
  logic                  step_from_now;
  logic [TIME_WIDTH-1:0] step_base;
  logic [FRAC_WIDTH-1:0] step_acc;
  logic [FRAC_WIDTH:0]   frac_sum;
  logic                  frac_carry;
  logic [TIME_WIDTH-1:0] step_deadline;
  logic [FRAC_WIDTH-1:0] step_acc_next;

  // frame done arithmetic
  logic [TIME_WIDTH-1:0] dur_base;
  logic [TIME_WIDTH-1:0] duration;
  logic                  is_late;
  logic [TIME_WIDTH-1:0] lateness;
  logic                  query_wait;

  // handshake control
  assign out_fire  = out_valid & m_tready;
  assign eval_fire = in_valid & (~out_valid | m_tready);
  assign s_tready  = ~in_valid | eval_fire;
  assign in_fire   = s_tvalid & s_tready;

  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_TDATA_W'(out_res);

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      throttled         <= THROTTLED_RST;
      frame_floor_ns    <= FLOOR_RST;
      frame_remainder   <= REMAINDER_RST;
      frame_denominator <= DENOM_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THROTTLED: throttled         <= cfg_data[0];
        CFG_FLOOR:     frame_floor_ns    <= cfg_data[FRAC_WIDTH-1:0];
        CFG_REMAINDER: frame_remainder   <= cfg_data[FRAC_WIDTH-1:0];
        CFG_DENOM:     frame_denominator <= cfg_data[FRAC_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      in_valid <= 1'b1;
    end else if (eval_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_op  <= s_tuser;
      in_now <= s_tdata[TIME_WIDTH-1:0];
    end
  end

  // deadline step: start steps from now with a cleared accumulator
  assign step_from_now = (in_op == OP_START);
  assign step_base     = step_from_now ? in_now : st.next_deadline;
  assign step_acc      = step_from_now ? '0 : st.fraction_acc;
  assign frac_sum      = {1'b0, step_acc} + {1'b0, frame_remainder};
  assign frac_carry    = (frac_sum >= {1'b0, frame_denominator});
  assign step_deadline = step_base + TIME_WIDTH'(frame_floor_ns) + TIME_WIDTH'(frac_carry);
  assign step_acc_next = frac_carry ? FRAC_WIDTH'(frac_sum - {1'b0, frame_denominator})
                                    : frac_sum[FRAC_WIDTH-1:0];

  // frame duration and lateness against the current deadline
  assign dur_base   = st.have_previous ? st.previous_done_time : st.start_time;
  assign duration   = in_now - dur_base;
  assign is_late    = (in_now > st.next_deadline);
  assign lateness   = in_now - st.next_deadline;
  assign query_wait = throttled & (in_now < st.wait_target);

  // state update and result for the word in the input register
  always_comb begin
    st_next = st;
    res_next.should_wait = 1'b0;
    case (in_op)
      OP_START: begin
        st_next               = '0;
        st_next.start_time    = in_now;
        st_next.wait_target   = in_now;
        st_next.next_deadline = step_deadline;
        st_next.fraction_acc  = step_acc_next;
      end
      OP_FRAME_DONE: begin
        st_next.frame_counter      = st.frame_counter + COUNT_WIDTH'(1);
        st_next.last_duration      = duration;
        st_next.have_previous      = 1'b1;
        st_next.previous_done_time = in_now;
        st_next.duration_sum       = st.duration_sum + duration;
        if (duration > st.worst_duration) begin
          st_next.worst_duration = duration;
        end
        if (!throttled) begin
          st_next.wait_target = in_now;
          st_next.last_late   = '0;
        end else begin
          st_next.wait_target = st.next_deadline;
          if (is_late) begin
            st_next.last_late    = lateness;
            st_next.late_counter = st.late_counter + COUNT_WIDTH'(1);
            if (lateness > st.max_late) begin
              st_next.max_late = lateness;
            end
          end else begin
            st_next.last_late = '0;
          end
          st_next.next_deadline = step_deadline;
          st_next.fraction_acc  = step_acc_next;
        end
      end
      OP_QUERY: begin
        res_next.should_wait = query_wait;
      end
      default: ;
    endcase
    res_next.wait_until       = st_next.wait_target;
    res_next.frames_done      = st_next.frame_counter;
    res_next.late_frames      = st_next.late_counter;
    res_next.last_frame_time  = st_next.last_duration;
    res_next.worst_frame_time = st_next.worst_duration;
    res_next.total_frame_time = st_next.duration_sum;
    res_next.last_lateness    = st_next.last_late;
    res_next.max_lateness     = st_next.max_late;
  end

  // pacing state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (eval_fire) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eval_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      out_res <= res_next;
    end
  end

  // checks
  `FFP_ASSERT_ALWAYS(a_late_below_max, st.last_late <= st.max_late, "last lateness above max")
  `FFP_ASSERT_ALWAYS(a_last_below_worst, st.last_duration <= st.worst_duration,
                     "last frame time above worst")
  `FFP_ASSERT_NEXT(a_frame_count, eval_fire && (in_op == OP_FRAME_DONE),
                   st.frame_counter == $past(st.frame_counter) + COUNT_WIDTH'(1),
                   "frame count did not advance")
  `FFP_ASSERT_NEXT(a_result_follows, eval_fire, out_valid, "evaluated word gave no result")
  `FFP_ASSERT_SAME(a_full_blocks, in_valid && out_valid && !m_tready, !s_tready,
                   "input accepted while both registers full")

endmodule

`default_nettype wire

/* test/fractional_frame_pacer_tb.sv */
// self-checking testbench of the fractional frame pacer: stream stimulus, scoreboard, watchdog
module fractional_frame_pacer_tb;
  import ffp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // code 3 carries no event, the block only echoes its state
  localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [TIME_WIDTH-1:0] PERIOD_RST = TIME_WIDTH'(FLOOR_RST);

  typedef struct {
    logic [OP_WIDTH-1:0]   code;
    logic [TIME_WIDTH-1:0] now;
  } pacer_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [OP_WIDTH-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fractional_frame_pacer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // events waiting to be offered and results waiting to arrive
  pacer_event_t pending[$];
  result_t due[$];
  int mismatches = 0;
  bit taken = 1'b0;

  // traffic shaping shared between the phase sequencer and the two sides
  bit src_gaps = 1'b1;
  bit snk_gaps = 1'b1;
  int hold_requests = 0;

  // register copies
  logic                  throttle_on = THROTTLED_RST;
  logic [FRAC_WIDTH-1:0] floor_ns    = FLOOR_RST;
  logic [FRAC_WIDTH-1:0] frac_num    = REMAINDER_RST;
  logic [FRAC_WIDTH-1:0] frac_den    = DENOM_RST;

  // pacing and statistics state of the predictor
  logic [TIME_WIDTH-1:0]  start_ns, target_ns, deadline_ns, prev_done_ns;
  logic [FRAC_WIDTH-1:0]  frac_acc;
  logic                   seen_frame;
  logic [COUNT_WIDTH-1:0] frame_cnt, late_cnt;
  logic [TIME_WIDTH-1:0]  last_dur, worst_dur, sum_dur, lag_recent, lag_peak;

  function automatic void clear_pacing();
    start_ns = '0;
    target_ns = '0;
    deadline_ns = '0;
    prev_done_ns = '0;
    frac_acc = '0;
    seen_frame = 1'b0;
    frame_cnt = '0;
    late_cnt = '0;
    last_dur = '0;
    worst_dur = '0;
    sum_dur = '0;
    lag_recent = '0;
    lag_peak = '0;
  endfunction

  // one period: whole ns plus a carry when the fraction wraps past the denominator
  function automatic void advance_deadline();
    logic [FRAC_WIDTH:0] frac_sum;
    frac_sum = {1'b0, frac_acc} + {1'b0, frac_num};
    deadline_ns = deadline_ns + TIME_WIDTH'(floor_ns);
    if (frac_sum >= {1'b0, frac_den}) begin
      deadline_ns = deadline_ns + 1'b1;
      frac_sum = frac_sum - {1'b0, frac_den};
    end
    frac_acc = frac_sum[FRAC_WIDTH-1:0];
  endfunction

  // apply one event to the predicted state and form the result word
  function automatic result_t pace_event(logic [OP_WIDTH-1:0] code, logic [TIME_WIDTH-1:0] now);
    result_t r;
    logic wait_flag;
    logic [TIME_WIDTH-1:0] origin;
    wait_flag = 1'b0;
    case (code)
      OP_START: begin
        clear_pacing();
        start_ns = now;
        target_ns = now;
        deadline_ns = now;
        advance_deadline();
      end
      OP_FRAME_DONE: begin
        origin = seen_frame ? prev_done_ns : start_ns;
        frame_cnt = frame_cnt + 1'b1;
        last_dur = now - origin;
        seen_frame = 1'b1;
        prev_done_ns = now;
        sum_dur = sum_dur + last_dur;
        if (last_dur > worst_dur) worst_dur = last_dur;
        if (!throttle_on) begin
          target_ns = now;
          lag_recent = '0;
        end else begin
          target_ns = deadline_ns;
          if (now > target_ns) begin
            lag_recent = now - target_ns;
            late_cnt = late_cnt + 1'b1;
            if (lag_recent > lag_peak) lag_peak = lag_recent;
          end else begin
            lag_recent = '0;
          end
          advance_deadline();
        end
      end
      OP_QUERY: begin
        wait_flag = throttle_on && (now < target_ns);
      end
      default: ;
    endcase
    r.should_wait = wait_flag;
    r.wait_until = target_ns;
    r.frames_done = frame_cnt;
    r.late_frames = late_cnt;
    r.last_frame_time = last_dur;
    r.worst_frame_time = worst_dur;
    r.total_frame_time = sum_dur;
    r.last_lateness = lag_recent;
    r.max_lateness = lag_peak;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] saw);
    if (saw !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %h got %h", $realtime, name, want, saw);
    end
  endfunction

  function automatic void check_word(result_t want, result_t saw);
    check_field("should_wait", want.should_wait, saw.should_wait);
    check_field("wait_until", want.wait_until, saw.wait_until);
    check_field("frames_done", want.frames_done, saw.frames_done);
    check_field("late_frames", want.late_frames, saw.late_frames);
    check_field("last_frame_time", want.last_frame_time, saw.last_frame_time);
    check_field("worst_frame_time", want.worst_frame_time, saw.worst_frame_time);
    check_field("total_frame_time", want.total_frame_time, saw.total_frame_time);
    check_field("last_lateness", want.last_lateness, saw.last_lateness);
    check_field("max_lateness", want.max_lateness, saw.max_lateness);
  endfunction

  // monitor: predict on each accepted event word, compare each accepted result word
  always @(posedge clk) begin
    result_t got;
    if (rst) begin
      taken = 1'b0;
    end else begin
      taken = s_tvalid && s_tready;
      if (taken) begin
        due.push_back(pace_event(s_tuser, s_tdata[TIME_WIDTH-1:0]));
        void'(pending.pop_front());
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[OUT_BITS-1:0]);
        if (due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result word with nothing expected", $realtime);
        end else begin
          check_word(due.pop_front(), got);
        end
      end
    end
  end

  // driver: bursts of offers with random gaps, valid held until accepted
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending[0].code;
        s_tdata <= IN_TDATA_W'(pending[0].now);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = src_gaps ? $urandom_range(1, 6) : 0;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: short random stalls, plus a long hold-off when one is requested
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (snk_gaps && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
    end
  end

  // watchdog on cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_event(logic [OP_WIDTH-1:0] code, logic [TIME_WIDTH-1:0] now);
    pacer_event_t e;
    e.code = code;
    e.now = now;
    pending.push_back(e);
  endfunction

  // a start followed by frames near the period, with polls in between
  function automatic int queue_session(int frames);
    logic [TIME_WIDTH-1:0] t, step;
    int count;
    case ($urandom_range(0, 3))
      0: t = {32'hFFFF_FFFF, $urandom};
      1: t = TIME_WIDTH'($urandom_range(0, 100));
      default: t = {$urandom, $urandom};
    endcase
    queue_event(OP_START, t);
    count = 1;
    for (int i = 0; i < frames; i++) begin
      if (floor_ns < 8) begin
        step = TIME_WIDTH'($urandom_range(0, 2 * floor_ns + 2));
      end else begin
        case ($urandom_range(0, 9))
          0: step = TIME_WIDTH'(floor_ns) * 3;
          1: step = TIME_WIDTH'(floor_ns);
          default: step = TIME_WIDTH'(floor_ns) - TIME_WIDTH'(floor_ns >> 2)
                          + TIME_WIDTH'($urandom_range(0, floor_ns >> 1));
        endcase
      end
      t = t + step;
      queue_event(OP_FRAME_DONE, t);
      count++;
      if ($urandom_range(0, 2) == 0) begin
        queue_event(OP_QUERY, t + TIME_WIDTH'($urandom_range(0, floor_ns)));
        count++;
      end
    end
    return count;
  endfunction

  // mostly well-formed sessions, some loose events of any code and time
  function automatic void fill_random(int n);
    int added;
    int k;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 6) == 0) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++)
          queue_event(OP_WIDTH'($urandom_range(0, 3)), {$urandom, $urandom});
        added += k;
      end else begin
        added += queue_session($urandom_range(1, 10));
      end
    end
  endfunction

  task automatic set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_THROTTLED: throttle_on = value[0];
      CFG_FLOOR:     floor_ns = value;
      CFG_REMAINDER: frac_num = value;
      CFG_DENOM:     frac_den = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until every event has been offered and every result checked
  task automatic drain();
    while (pending.size() != 0 || due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_phase(int n, bit gaps_in, bit gaps_out, bit squeeze);
    @(posedge clk);
    src_gaps = gaps_in;
    snk_gaps = gaps_out;
    if (squeeze) hold_requests++;
    fill_random(n);
    drain();
  endtask

  // phase sequencer
  initial begin
    logic [CFG_DATA_W-1:0] den;
    clear_pacing();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed events under the reset settings
    queue_event(OP_FRAME_DONE, 64'd5);                 // frame before any start
    queue_event(OP_QUERY, 64'd0);
    queue_event(OP_UNUSED, '1);
    queue_event(OP_START, 64'd1000);
    queue_event(OP_QUERY, 64'd1000);                   // exactly at the target
    queue_event(OP_QUERY, 64'd999);
    queue_event(OP_FRAME_DONE, 64'd1000 + PERIOD_RST); // exactly on the deadline
    queue_event(OP_QUERY, 64'd999 + PERIOD_RST);
    queue_event(OP_FRAME_DONE, 64'd1500 + 2 * PERIOD_RST);
    queue_event(OP_FRAME_DONE, 64'd1000 + 10 * PERIOD_RST);
    queue_event(OP_FRAME_DONE, 64'd1000 + 10 * PERIOD_RST); // zero duration
    queue_event(OP_FRAME_DONE, 64'd1000);              // time going backwards
    queue_event(OP_START, 64'hFFFF_FFFF_FFFF_FF00);    // deadline wraps past zero
    queue_event(OP_QUERY, '1);
    queue_event(OP_FRAME_DONE, '1);
    queue_event(OP_FRAME_DONE, 64'd100);
    queue_event(OP_QUERY, 64'd0);
    queue_event(OP_UNUSED, 64'd0);
    queue_event(OP_START, 64'd0);
    queue_event(OP_FRAME_DONE, 64'h5555_5555_5555_5555);
    queue_event(OP_FRAME_DONE, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_event(OP_QUERY, 64'hAAAA_AAAA_AAAA_AAA9);
    drain();

    // unthrottled
    set_reg(CFG_THROTTLED, 32'd0);
    set_reg(CFG_FLOOR, 32'd1000);
    run_phase(100, 1'b1, 1'b1, 1'b0);

    // two-thirds fraction, with a long output hold-off
    set_reg(CFG_THROTTLED, 32'd1);
    set_reg(CFG_FLOOR, 32'd16666666);
    set_reg(CFG_REMAINDER, 32'd2);
    set_reg(CFG_DENOM, 32'd3);
    run_phase(110, 1'b0, 1'b0, 1'b1);

    // widest period and fraction
    set_reg(CFG_FLOOR, 32'hFFFF_FFFF);
    set_reg(CFG_DENOM, 32'hFFFF_FFFF);
    set_reg(CFG_REMAINDER, 32'hFFFF_FFFE);
    run_phase(90, 1'b0, 1'b1, 1'b0);

    // remainder above the denominator, one-ns floor
    set_reg(CFG_FLOOR, 32'd1);
    set_reg(CFG_REMAINDER, 32'hFFFF_FFFF);
    set_reg(CFG_DENOM, 32'd5);
    run_phase(90, 1'b1, 1'b1, 1'b0);

    // zero denominator and zero floor, no idling on either side
    set_reg(CFG_FLOOR, 32'd0);
    set_reg(CFG_REMAINDER, 32'd7);
    set_reg(CFG_DENOM, 32'd0);
    run_phase(80, 1'b0, 1'b0, 1'b0);

    // random settings
    for (int p = 0; p < 3; p++) begin
      den = $urandom;
      set_reg(CFG_THROTTLED, $urandom);
      set_reg(CFG_FLOOR, $urandom);
      set_reg(CFG_DENOM, den);
      set_reg(CFG_REMAINDER, ($urandom_range(0, 3) == 0 || den == 0) ? $urandom : $urandom % den);
      run_phase(90, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, p == 0);
    end

    if (mismatches == 0 && due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
